FILE: design/threshold_table_level_quantizer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the threshold table level quantizer
// Shared property wrappers: same-cycle and next-cycle implication under reset.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_TABLE_LEVEL_QUANTIZER_MACROS_SVH
`define THRESHOLD_TABLE_LEVEL_QUANTIZER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TTLQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ttlq: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define TTLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ttlq: next-cycle check failed");

`endif

FILE: design/ttlq_pkg.sv
// ----------------------------------------------------------------------------
// ttlq_pkg
// Types, codes and constants shared by the threshold table level quantizer.
// ----------------------------------------------------------------------------
package ttlq_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int MAX_LEVELS_DEF  = 191;

	localparam int SAMPLE_W    = 32;
	localparam int THRESH_W    = 24;
	localparam int FRAC_BITS   = 8;
	localparam int IDX_W       = 8;
	localparam int LEVEL_W     = 8;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam int MISSING_FLOOR = -90000;
	localparam int SR2_SPLIT     = 63;
	localparam int SR2_END       = 127;

	localparam logic signed [SAMPLE_W-1:0] FLOOR_W =
		SAMPLE_W'(MISSING_FLOOR * (1 << FRAC_BITS));

	// input operation codes
	localparam logic OP_WRITE    = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(1);

	// search modes
	localparam logic [MODE_W-1:0] MODE_DEFAULT = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_SR2     = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_SRJ     = MODE_W'(2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic             wr_en;
		logic             capture;
		logic             shift;
		logic [IDX_W-1:0] rd_addr;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ge_cur;
		logic eq_cur;
		logic ge_prev;
		logic eq_prev;
		logic is_neg;
		logic below_floor;
	} dp_stat_t;

endpackage

FILE: design/threshold_table_level_quantizer.sv
// ----------------------------------------------------------------------------
// threshold_table_level_quantizer
// Maps samples to level indexes by scanning a table of lower bounds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per item. op selects a
//   table row write (entry_index, threshold) or a classify (sample,
//   last_sample). Output channel (out_valid/out_ready) returns one word,
//   level and last, per classify; writes return nothing.
//   Config channel (cfg_valid/cfg_ready, always ready) sets mode and
//   row_count; write it only while no classify is in flight.
// Timing:
//   A write is taken while idle, and the next word may follow at once.
//   A classify scans the table one row per cycle through the single memory
//   read port, R rows in all (at least one, at most nlev-1 in default/srj
//   mode, up to 128 in sr2 mode); the result then moves to the output
//   register, and only then is the next word taken.
// Reset clears the sequencer, config and output valid; the table is not
//   cleared and must be loaded before classifying.
// A stalled receiver holds the result in the output register; the next
//   word is still accepted and scanned, and waits before delivery.
// ----------------------------------------------------------------------------
`include "threshold_table_level_quantizer_macros.svh"

module threshold_table_level_quantizer #(
	parameter int TABLE_DEPTH = ttlq_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_LEVELS  = ttlq_pkg::MAX_LEVELS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic [ttlq_pkg::IDX_W-1:0]           entry_index,
	input  logic signed [ttlq_pkg::THRESH_W-1:0] threshold,
	input  logic signed [ttlq_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 last_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [ttlq_pkg::LEVEL_W-1:0]         level,
	output logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ttlq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ttlq_pkg::CFG_DATA_W-1:0]      cfg_data
);

	ttlq_pkg::dp_cmd_t  dp_cmd;
	ttlq_pkg::dp_stat_t dp_stat;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	// sequence writes and scans, hold config and the output word
	ttlq_ctrl #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.last_sample (last_sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.level       (level),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (dp_cmd),
		.stat        (dp_stat)
	);

	// store bounds, hold the sample, compare against current and previous row
	ttlq_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.entry_index (entry_index),
		.threshold   (threshold),
		.sample      (sample),
		.stat        (dp_stat)
	);

	// a table write only happens on an accepted word
	`TTLQ_ASSERT_NOW(a_wr_on_accept, clk, arst_n, dp_cmd.wr_en, in_valid && in_ready)
	// never write and start a scan in the same cycle
	`TTLQ_ASSERT_NOW(a_wr_xor_cap, clk, arst_n, dp_cmd.capture, !dp_cmd.wr_en)
	// a classify blocks the input while its scan runs
	`TTLQ_ASSERT_NEXT(a_busy_after_cap, clk, arst_n, dp_cmd.capture, !in_ready)
	// a write never stalls the input
	`TTLQ_ASSERT_NEXT(a_wr_no_stall, clk, arst_n, dp_cmd.wr_en, in_ready)

endmodule

FILE: design/ttlq_dp.sv
// ----------------------------------------------------------------------------
// ttlq_dp
// Threshold memory, sample register and bound comparators.
// ----------------------------------------------------------------------------
module ttlq_dp #(
	parameter int TABLE_DEPTH = ttlq_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ttlq_pkg::dp_cmd_t                    cmd,
	input  logic [ttlq_pkg::IDX_W-1:0]           entry_index,
	input  logic signed [ttlq_pkg::THRESH_W-1:0] threshold,
	input  logic signed [ttlq_pkg::SAMPLE_W-1:0] sample,
	output ttlq_pkg::dp_stat_t                   stat
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int IW = (AW > ttlq_pkg::IDX_W) ? AW : ttlq_pkg::IDX_W;

	logic [ttlq_pkg::THRESH_W-1:0] mem [TABLE_DEPTH];

	logic [IW:0]                          wr_ext;
	logic [IW:0]                          rd_ext;
	logic                                 wr_ok;
	logic                                 rd_ok;
	logic [ttlq_pkg::THRESH_W-1:0]        rd_data_q;
	logic                                 rd_ok_q;
	logic signed [ttlq_pkg::SAMPLE_W-1:0] sample_q;
	logic signed [ttlq_pkg::SAMPLE_W-1:0] prev_q;
	logic signed [ttlq_pkg::SAMPLE_W-1:0] cur_b;

	assign wr_ext = (IW + 1)'(entry_index);
	assign rd_ext = (IW + 1)'(cmd.rd_addr);
	assign wr_ok  = wr_ext < (IW + 1)'(TABLE_DEPTH);
	assign rd_ok  = rd_ext < (IW + 1)'(TABLE_DEPTH);

	// drop writes beyond the table
	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			mem[wr_ext[AW-1:0]] <= threshold;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_ext[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= rd_ok;
		end
	end

	// rows beyond the table read as zero
	assign cur_b = rd_ok_q ? {rd_data_q, {ttlq_pkg::FRAC_BITS{1'b0}}} : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
		end
		if (cmd.shift) begin
			prev_q <= cur_b;
		end
	end

	always_comb begin
		stat.ge_cur      = sample_q >= cur_b;
		stat.eq_cur      = sample_q == cur_b;
		stat.ge_prev     = sample_q >= prev_q;
		stat.eq_prev     = sample_q == prev_q;
		stat.is_neg      = sample_q[ttlq_pkg::SAMPLE_W-1];
		stat.below_floor = sample_q < ttlq_pkg::FLOOR_W;
	end

endmodule

FILE: design/ttlq_ctrl.sv
// ----------------------------------------------------------------------------
// ttlq_ctrl
// Sequencer for table writes and row scans, config and output registers.
// ----------------------------------------------------------------------------
module ttlq_ctrl #(
	parameter int MAX_LEVELS = ttlq_pkg::MAX_LEVELS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic                                 last_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [ttlq_pkg::LEVEL_W-1:0]         level,
	output logic                                 last,
	input  logic                                 cfg_valid,
	input  logic [ttlq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ttlq_pkg::CFG_DATA_W-1:0]      cfg_data,
	output ttlq_pkg::dp_cmd_t                    cmd,
	input  ttlq_pkg::dp_stat_t                   stat
);

	localparam int NW = ttlq_pkg::IDX_W + 1;

	ttlq_pkg::state_t state_q, state_d;

	logic [ttlq_pkg::MODE_W-1:0]  mode_q;
	logic [ttlq_pkg::IDX_W-1:0]   row_count_q;
	logic [ttlq_pkg::IDX_W-1:0]   k_q;
	logic [ttlq_pkg::LEVEL_W-1:0] res_q;
	logic                         item_last_q;
	logic                         out_valid_q;
	logic [ttlq_pkg::LEVEL_W-1:0] level_q;
	logic                         last_q;

	logic [NW-1:0]                nlev_raw;
	logic [NW-1:0]                nlev;
	logic                         nlev_one;
	logic [ttlq_pkg::IDX_W-1:0]   last_k;
	logic [ttlq_pkg::IDX_W-1:0]   k_inc;
	logic                         up_pair;
	logic                         down_pair;
	logic                         scan_done;
	logic [ttlq_pkg::LEVEL_W-1:0] scan_level;
	logic                         accept;
	logic                         out_free;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign k_inc    = k_q + ttlq_pkg::IDX_W'(1);

	assign nlev_raw = NW'(row_count_q) + NW'(1);
	assign nlev     = (nlev_raw > NW'(MAX_LEVELS)) ? NW'(MAX_LEVELS) : nlev_raw;
	assign nlev_one = nlev == NW'(1);
	assign last_k   = ttlq_pkg::IDX_W'(nlev - NW'(2));

	// prev row is the lower bound going up, the upper bound going down
	assign up_pair   = (stat.eq_prev && stat.eq_cur) || (stat.ge_prev && !stat.ge_cur);
	assign down_pair = (stat.eq_prev && stat.eq_cur) || (stat.ge_cur && !stat.ge_prev);

	// decide on the row that just arrived
	always_comb begin
		scan_done  = 1'b0;
		scan_level = '0;
		unique case (mode_q)
			ttlq_pkg::MODE_SR2: begin
				if (stat.below_floor) begin
					scan_done = 1'b1;
				end else if (k_q != '0 && k_q <= ttlq_pkg::IDX_W'(ttlq_pkg::SR2_SPLIT)
						&& up_pair) begin
					scan_done  = 1'b1;
					scan_level = k_q;
				end else if (k_q == ttlq_pkg::IDX_W'(ttlq_pkg::SR2_SPLIT) && stat.ge_cur) begin
					scan_done  = 1'b1;
					scan_level = k_inc;
				end else if (k_q > ttlq_pkg::IDX_W'(ttlq_pkg::SR2_SPLIT) && down_pair) begin
					scan_done  = 1'b1;
					scan_level = k_inc;
				end else if (k_q == ttlq_pkg::IDX_W'(ttlq_pkg::SR2_END)) begin
					scan_done  = 1'b1;
					scan_level = ttlq_pkg::LEVEL_W'(ttlq_pkg::SR2_END);
				end
			end
			ttlq_pkg::MODE_SRJ: begin
				if (stat.below_floor || nlev_one) begin
					scan_done = 1'b1;
				end else if (stat.eq_cur || k_q == last_k) begin
					// no match by the last row gives the top level, also k+1
					scan_done  = 1'b1;
					scan_level = k_inc;
				end
			end
			default: begin
				if (stat.is_neg || nlev_one) begin
					scan_done = 1'b1;
				end else if (k_q != '0 && up_pair) begin
					scan_done  = 1'b1;
					scan_level = k_q;
				end else if (k_q == last_k) begin
					// open top interval and the fallback both land on nlev-1
					scan_done  = 1'b1;
					scan_level = k_inc;
				end
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttlq_pkg::ST_IDLE: begin
				if (accept && op == ttlq_pkg::OP_CLASSIFY) begin
					state_d = ttlq_pkg::ST_SCAN;
				end
			end
			ttlq_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = ttlq_pkg::ST_HOLD;
				end
			end
			ttlq_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = ttlq_pkg::ST_IDLE;
				end
			end
			default: state_d = ttlq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.wr_en   = 1'b0;
		cmd.capture = 1'b0;
		cmd.shift   = 1'b0;
		cmd.rd_addr = '0;
		unique case (state_q)
			ttlq_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.wr_en   = in_valid && op == ttlq_pkg::OP_WRITE;
				cmd.capture = in_valid && op == ttlq_pkg::OP_CLASSIFY;
			end
			ttlq_pkg::ST_SCAN: begin
				cmd.shift   = 1'b1;
				cmd.rd_addr = k_inc;
			end
			ttlq_pkg::ST_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ttlq_pkg::ST_IDLE;
			mode_q      <= ttlq_pkg::MODE_DEFAULT;
			row_count_q <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					ttlq_pkg::CFG_MODE:      mode_q      <= cfg_data[ttlq_pkg::MODE_W-1:0];
					ttlq_pkg::CFG_ROW_COUNT: row_count_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ttlq_pkg::ST_SCAN) begin
				k_q <= k_inc;
			end else begin
				k_q <= '0;
			end
			if (state_q == ttlq_pkg::ST_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_last_q <= last_sample;
		end
		if (state_q == ttlq_pkg::ST_SCAN && scan_done) begin
			res_q <= scan_level;
		end
		if (state_q == ttlq_pkg::ST_HOLD && out_free) begin
			level_q <= res_q;
			last_q  <= item_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign last      = last_q;

endmodule
